// File: rtl/core/pgss_pkg.sv
`default_nettype none

package pgss_pkg;

  // field widths fixed by the interface
  localparam int CMD_W   = 2;
  localparam int COORD_W = 16;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 7;
  localparam int CFG_IDX_W = 1;

  // default lattice bounds
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_HEIGHT_DEF = 64;

  // size register value after reset
  localparam logic [CFG_W-1:0] GRID_SIZE_RESET = 7'd64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'd1;

  // request commands
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd2;

  // neighborhood layout, row by row
  localparam int NB_COUNT  = 9;
  localparam int NB_CENTER = 4;
  localparam int NB_SIDE   = 3;

endpackage

`default_nettype wire

// File: rtl/core/pgss_wrap.sv
`default_nettype none

// Iterative true-modulo of a signed coordinate by a size, two bits per cycle while step is high.
module pgss_wrap
  import pgss_pkg::*;
#(
  parameter int SIZE_MAX = MAX_WIDTH_DEF
) (
  input  wire                       clk,
  input  wire                       load,
  input  wire                       step,
  input  wire signed [COORD_W-1:0]  coord,
  input  wire [$clog2(SIZE_MAX+1)-1:0] size,
  output logic [((SIZE_MAX > 1) ? $clog2(SIZE_MAX) : 1)-1:0] pos
);

  localparam int SW = $clog2(SIZE_MAX + 1);
  localparam int XW = (SIZE_MAX > 1) ? $clog2(SIZE_MAX) : 1;

  logic [COORD_W-1:0] mag, mag_next;
  logic [SW-1:0]      rem, rem_next;
  logic               neg;

  always_comb begin
    logic [SW:0]        t;
    logic [SW-1:0]      r;
    logic [COORD_W-1:0] m;
    r = rem;
    m = mag;
    for (int i = 0; i < 2; i++) begin
      t = {r, m[COORD_W-1]};
      m = {m[COORD_W-2:0], 1'b0};
      if (t >= {1'b0, size}) begin
        t = t - {1'b0, size};
      end
      r = t[SW-1:0];
    end
    rem_next = r;
    mag_next = m;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      neg <= coord[COORD_W-1];
      mag <= coord[COORD_W-1] ? COORD_W'(-coord) : COORD_W'(coord);
      rem <= '0;
    end else if (step) begin
      mag <= mag_next;
      rem <= rem_next;
    end
  end

  // negative operand with nonzero remainder folds back into range
  assign pos = (neg && rem != '0) ? XW'(size - rem) : XW'(rem);

endmodule

`default_nettype wire

// File: rtl/core/pgss_front.sv
`default_nettype none

// Accepts requests, wraps the coordinate, forms neighbor columns and row bases.
module pgss_front
  import pgss_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int SWX = $clog2(MAX_WIDTH + 1),
  localparam int SWY = $clog2(MAX_HEIGHT + 1),
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int AW  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1,
  localparam int DW  = CMD_W + DATA_W + NB_SIDE * (XW + AW)
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  output logic                     busy,
  input  wire [CMD_W-1:0]          cmd,
  input  wire signed [COORD_W-1:0] coord_x,
  input  wire signed [COORD_W-1:0] coord_y,
  input  wire signed [DATA_W-1:0]  value,
  input  wire [SWX-1:0]            w_eff,
  input  wire [SWY-1:0]            h_eff,
  output logic                     q_push,
  output logic [DW-1:0]            q_data,
  input  wire                      q_full
);

  localparam int YW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DIV_CYC = COORD_W / 2;
  localparam int CW      = (DIV_CYC > 1) ? $clog2(DIV_CYC) : 1;

  typedef enum logic [2:0] {F_IDLE, F_DIV, F_FIX, F_ROWS, F_PUSH} fstate_t;

  fstate_t              state;
  logic [CW-1:0]        cnt;
  logic [CMD_W-1:0]     cmd_q;
  logic [DATA_W-1:0]    val_q;
  logic [XW-1:0]        x0;
  logic [YW-1:0]        y0;
  logic [XW-1:0]        pos_x;
  logic [YW-1:0]        pos_y;
  logic [XW-1:0]        xm, xp;
  logic [YW-1:0]        ym, yp;
  logic [NB_SIDE-1:0][XW-1:0] ent_col;
  logic [NB_SIDE-1:0][AW-1:0] ent_row;
  logic                 load;
  logic                 step;

  assign busy = (state != F_IDLE);
  assign load = (state == F_IDLE) && start;
  assign step = (state == F_DIV);

  pgss_wrap #(.SIZE_MAX(MAX_WIDTH)) u_wrap_x (
    .clk   (clk),
    .load  (load),
    .step  (step),
    .coord (coord_x),
    .size  (w_eff),
    .pos   (pos_x)
  );

  pgss_wrap #(.SIZE_MAX(MAX_HEIGHT)) u_wrap_y (
    .clk   (clk),
    .load  (load),
    .step  (step),
    .coord (coord_y),
    .size  (h_eff),
    .pos   (pos_y)
  );

  // neighbors with periodic wrap at both edges
  always_comb begin
    xm = (x0 == '0) ? XW'(w_eff - SWX'(1)) : XW'(x0 - XW'(1));
    xp = (SWX'(x0) + SWX'(1) == w_eff) ? '0 : XW'(x0 + XW'(1));
    ym = (y0 == '0) ? YW'(h_eff - SWY'(1)) : YW'(y0 - YW'(1));
    yp = (SWY'(y0) + SWY'(1) == h_eff) ? '0 : YW'(y0 + YW'(1));
  end

  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = {cmd_q, val_q, ent_col, ent_row};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            val_q <= value;
            cnt   <= '0;
            state <= F_DIV;
          end
        end
        F_DIV: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DIV_CYC - 1)) begin
            state <= F_FIX;
          end
        end
        F_FIX: begin
          x0    <= pos_x;
          y0    <= pos_y;
          state <= F_ROWS;
        end
        F_ROWS: begin
          ent_col[0] <= xm;
          ent_col[1] <= x0;
          ent_col[2] <= xp;
          ent_row[0] <= AW'(AW'(ym) * AW'(w_eff));
          ent_row[1] <= AW'(AW'(y0) * AW'(w_eff));
          ent_row[2] <= AW'(AW'(yp) * AW'(w_eff));
          state      <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pgss_queue.sv
`default_nettype none

// Two-entry request queue between front and back.
module pgss_queue
  import pgss_pkg::*;
#(
  parameter int DW = CMD_W + DATA_W
) (
  input  wire           clk,
  input  wire           rst,
  input  wire           push,
  input  wire [DW-1:0]  push_data,
  output logic          full,
  input  wire           pop,
  output logic [DW-1:0] pop_data,
  output logic          empty
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop)  rd_ptr <= rd_ptr + PW'(1);
      priority if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/pgss_back.sv
`default_nettype none

// Carries out queued requests against the lattice memory through one read port.
module pgss_back
  import pgss_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
  localparam int AW  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1,
  localparam int DW  = CMD_W + DATA_W + NB_SIDE * (XW + AW)
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               q_empty,
  input  wire [DW-1:0]                      q_data,
  output logic                              q_pop,
  output logic                              done,
  output logic [NB_COUNT-1:0][DATA_W-1:0]   nbhd,
  output logic                              saturated
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int KW    = $clog2(NB_COUNT + 1);
  localparam int SPW   = $clog2(NB_SIDE);

  typedef enum logic [2:0] {B_IDLE, B_READ, B_WRITE, B_ADD_RD, B_ADD, B_NOP} bstate_t;

  bstate_t                    state;
  logic [CMD_W-1:0]           q_cmd;
  logic [DATA_W-1:0]          q_val;
  logic [NB_SIDE-1:0][XW-1:0] q_col;
  logic [NB_SIDE-1:0][AW-1:0] q_row;
  logic [DATA_W-1:0]          val;
  logic [NB_SIDE-1:0][XW-1:0] col;
  logic [NB_SIDE-1:0][AW-1:0] row;
  logic [SPW-1:0]             rs, cs;
  logic [KW-1:0]              iss;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr, ctr_addr;
  logic              mem_we;
  logic [DATA_W-1:0] wr_data;
  logic [DATA_W:0]   sum;
  logic              sum_ovf;
  logic [DATA_W-1:0] sum_clip;

  assign {q_cmd, q_val, q_col, q_row} = q_data;
  assign q_pop = (state == B_IDLE) && !q_empty;

  assign ctr_addr = row[1] + AW'(col[1]);

  // sign-extended add, clipped to the 32-bit range
  always_comb begin
    sum      = {rd_data[DATA_W-1], rd_data} + {val[DATA_W-1], val};
    sum_ovf  = (sum[DATA_W] != sum[DATA_W-1]);
    sum_clip = sum_ovf ? {sum[DATA_W], {(DATA_W-1){~sum[DATA_W]}}} : sum[DATA_W-1:0];
  end

  always_comb begin
    rd_addr = (state == B_READ) ? row[rs] + AW'(col[cs]) : ctr_addr;
    mem_we  = (state == B_WRITE) || (state == B_ADD);
    wr_data = (state == B_ADD) ? sum_clip : val;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ctr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            val       <= q_val;
            col       <= q_col;
            row       <= q_row;
            rs        <= '0;
            cs        <= '0;
            iss       <= '0;
            nbhd      <= '0;
            saturated <= 1'b0;
            unique case (q_cmd)
              CMD_READ:  state <= B_READ;
              CMD_WRITE: state <= B_WRITE;
              CMD_ADD:   state <= B_ADD_RD;
              default:   state <= B_NOP;
            endcase
          end
        end
        B_READ: begin
          // read data arrives in the cycle after its address
          if (iss != '0) begin
            nbhd[4'(iss - KW'(1))] <= rd_data;
          end
          if (iss == KW'(NB_COUNT)) begin
            done  <= 1'b1;
            state <= B_IDLE;
          end else begin
            iss <= iss + KW'(1);
            if (iss < KW'(NB_COUNT - 1)) begin
              if (cs == SPW'(NB_SIDE - 1)) begin
                cs <= '0;
                rs <= rs + SPW'(1);
              end else begin
                cs <= cs + SPW'(1);
              end
            end
          end
        end
        B_WRITE: begin
          nbhd[NB_CENTER] <= val;
          done            <= 1'b1;
          state           <= B_IDLE;
        end
        B_ADD_RD: begin
          state <= B_ADD;
        end
        B_ADD: begin
          nbhd[NB_CENTER] <= sum_clip;
          saturated       <= sum_ovf;
          done            <= 1'b1;
          state           <= B_IDLE;
        end
        B_NOP: begin
          done  <= 1'b1;
          state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/periodic_grid_stencil_store.sv
`default_nettype none

// Periodic 2D lattice store with 3x3 neighborhood reads.
// Request channel: a request (cmd, coord_x, coord_y, value) is taken on a clock
//   edge with start high and busy low. cmd: read neighborhood, write value,
//   saturating add or no-op. Coordinates wrap modulo grid_width / grid_height.
// Result channel: done pulses for one cycle with the nine neighborhood words
//   and saturated on the ports; the receiver cannot hold results off, so the
//   block never stalls on the output side.
// Config: cfg_write with cfg_index/cfg_data sets grid_width (0) or grid_height
//   (1); write only while no request is outstanding.
// Timing: the front end takes one request at a time (radix-4 modulo, fix-up,
//   row multiply, queue push) and no new one until the push, which waits
//   while the queue is full. The back end pops a request, then makes nine
//   reads through the single memory read port for a read, a read and a write
//   for an add, or one write. A 2-entry queue sits between them.
// Reset: sync, active high; sizes return to 64, queue and FSMs clear.
//   Lattice contents are not cleared; read only entries already written.
module periodic_grid_stencil_store
  import pgss_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  // request
  input  wire                      start,
  output logic                     busy,
  input  wire [CMD_W-1:0]          cmd,
  input  wire signed [COORD_W-1:0] coord_x,
  input  wire signed [COORD_W-1:0] coord_y,
  input  wire signed [DATA_W-1:0]  value,
  // configuration
  input  wire                      cfg_write,
  input  wire [CFG_IDX_W-1:0]      cfg_index,
  input  wire [CFG_W-1:0]          cfg_data,
  // result
  output logic                     done,
  output logic signed [DATA_W-1:0] up_left,
  output logic signed [DATA_W-1:0] up_mid,
  output logic signed [DATA_W-1:0] up_right,
  output logic signed [DATA_W-1:0] mid_left,
  output logic signed [DATA_W-1:0] center,
  output logic signed [DATA_W-1:0] mid_right,
  output logic signed [DATA_W-1:0] down_left,
  output logic signed [DATA_W-1:0] down_mid,
  output logic signed [DATA_W-1:0] down_right,
  output logic                     saturated
);

  localparam int SWX = $clog2(MAX_WIDTH + 1);
  localparam int SWY = $clog2(MAX_HEIGHT + 1);
  localparam int XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AW  = (MAX_WIDTH * MAX_HEIGHT > 1) ? $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int DW  = CMD_W + DATA_W + NB_SIDE * (XW + AW);

  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;
  logic [SWX-1:0]   w_eff;
  logic [SWY-1:0]   h_eff;

  logic          q_push, q_pop, q_full, q_empty;
  logic [DW-1:0] q_in, q_out;
  logic [NB_COUNT-1:0][DATA_W-1:0] nbhd;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_SIZE_RESET;
      grid_height <= GRID_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  grid_width  <= cfg_data;
        REG_GRID_HEIGHT: grid_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the bound acts as the bound
  always_comb begin
    priority if (grid_width == '0) begin
      w_eff = SWX'(1);
    end else if (32'(grid_width) > MAX_WIDTH) begin
      w_eff = SWX'(MAX_WIDTH);
    end else begin
      w_eff = SWX'(grid_width);
    end
    priority if (grid_height == '0) begin
      h_eff = SWY'(1);
    end else if (32'(grid_height) > MAX_HEIGHT) begin
      h_eff = SWY'(MAX_HEIGHT);
    end else begin
      h_eff = SWY'(grid_height);
    end
  end

  pgss_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .cmd     (cmd),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .value   (value),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .q_push  (q_push),
    .q_data  (q_in),
    .q_full  (q_full)
  );

  pgss_queue #(.DW(DW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  pgss_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .done      (done),
    .nbhd      (nbhd),
    .saturated (saturated)
  );

  // neighborhood words, row by row from the upper-left corner
  assign up_left    = signed'(nbhd[0]);
  assign up_mid     = signed'(nbhd[1]);
  assign up_right   = signed'(nbhd[2]);
  assign mid_left   = signed'(nbhd[3]);
  assign center     = signed'(nbhd[4]);
  assign mid_right  = signed'(nbhd[5]);
  assign down_left  = signed'(nbhd[6]);
  assign down_mid   = signed'(nbhd[7]);
  assign down_right = signed'(nbhd[8]);

endmodule

`default_nettype wire

// File: tb/periodic_grid_stencil_store_checker.sv
module periodic_grid_stencil_store_checker
  import pgss_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      start,
  input  wire                      busy,
  input  wire [CMD_W-1:0]          cmd,
  input  wire signed [COORD_W-1:0] coord_x,
  input  wire signed [COORD_W-1:0] coord_y,
  input  wire signed [DATA_W-1:0]  value,
  input  wire                      cfg_write,
  input  wire [CFG_IDX_W-1:0]      cfg_index,
  input  wire [CFG_W-1:0]          cfg_data,
  input  wire                      done,
  input  wire signed [DATA_W-1:0]  up_left,
  input  wire signed [DATA_W-1:0]  up_mid,
  input  wire signed [DATA_W-1:0]  up_right,
  input  wire signed [DATA_W-1:0]  mid_left,
  input  wire signed [DATA_W-1:0]  center,
  input  wire signed [DATA_W-1:0]  mid_right,
  input  wire signed [DATA_W-1:0]  down_left,
  input  wire signed [DATA_W-1:0]  down_mid,
  input  wire signed [DATA_W-1:0]  down_right,
  input  wire                      saturated,
  output int                       pending,
  output int                       fails
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NB_COUNT-1:0][DATA_W-1:0] words;
    logic                            sat;
  } stencil_t;

  logic [DATA_W-1:0] shadow_lattice [MAX_WIDTH*MAX_HEIGHT];
  logic [CFG_W-1:0]  width_code;
  logic [CFG_W-1:0]  height_code;
  stencil_t          pending_stencils [$];
  stencil_t          seen;
  stencil_t          want;

  string stencil_field [NB_COUNT] = '{"up_left", "up_mid", "up_right", "mid_left", "center",
                                      "mid_right", "down_left", "down_mid", "down_right"};

  // zero acts as one, oversize codes clamp to the lattice bound
  function automatic int grid_span(logic [CFG_W-1:0] code, int limit);
    if (code == '0) return 1;
    if (int'(code) > limit) return limit;
    return int'(code);
  endfunction

  function automatic int wrap_mod(int c, int n);
    int m;
    m = c % n;
    if (m < 0) m += n;
    return m;
  endfunction

  function automatic int lattice_addr(int x, int y);
    int w;
    int h;
    w = grid_span(width_code, MAX_WIDTH);
    h = grid_span(height_code, MAX_HEIGHT);
    return wrap_mod(x, w) + wrap_mod(y, h) * w;
  endfunction

  // updates the shadow lattice and returns what the block should answer
  function automatic stencil_t compute_stencil(logic [CMD_W-1:0] op,
                                               logic signed [COORD_W-1:0] x,
                                               logic signed [COORD_W-1:0] y,
                                               logic [DATA_W-1:0] v);
    stencil_t r;
    int       k;
    int       a;
    longint   sum;
    r = '0;
    k = 0;
    a = lattice_addr(int'(x), int'(y));
    case (op)
      CMD_READ: begin
        for (int dy = -1; dy <= 1; dy++) begin
          for (int dx = -1; dx <= 1; dx++) begin
            r.words[k] = shadow_lattice[lattice_addr(int'(x) + dx, int'(y) + dy)];
            k++;
          end
        end
      end
      CMD_WRITE: begin
        shadow_lattice[a] = v;
        r.words[NB_CENTER] = v;
      end
      CMD_ADD: begin
        sum = longint'($signed(shadow_lattice[a])) + longint'($signed(v));
        if (sum > 64'sd2147483647) begin
          sum = 64'sd2147483647;
          r.sat = 1'b1;
        end else if (sum < -64'sd2147483648) begin
          sum = -64'sd2147483648;
          r.sat = 1'b1;
        end
        shadow_lattice[a] = sum[DATA_W-1:0];
        r.words[NB_CENTER] = sum[DATA_W-1:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got_w,
                                 logic [DATA_W-1:0] want_w);
    $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got_w, want_w);
    fails++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_code = GRID_SIZE_RESET;
      height_code = GRID_SIZE_RESET;
      pending_stencils.delete();
    end else begin
      if (cfg_write) begin
        if (cfg_index == REG_GRID_WIDTH) width_code = cfg_data;
        else if (cfg_index == REG_GRID_HEIGHT) height_code = cfg_data;
      end
      // compare before pushing: a result never belongs to a request taken at the same edge
      if (done) begin
        seen.words = {down_right, down_mid, down_left, mid_right, center,
                      mid_left, up_right, up_mid, up_left};
        seen.sat = saturated;
        if (pending_stencils.size() == 0) begin
          report_mismatch("result with no request waiting", seen.words[NB_CENTER], '0);
        end else begin
          want = pending_stencils.pop_front();
          for (int k = 0; k < NB_COUNT; k++) begin
            if (seen.words[k] !== want.words[k])
              report_mismatch(stencil_field[k], seen.words[k], want.words[k]);
          end
          if (seen.sat !== want.sat)
            report_mismatch("saturated", DATA_W'(seen.sat), DATA_W'(want.sat));
        end
      end
      if (start && !busy)
        pending_stencils.insert(pending_stencils.size(),
                                compute_stencil(cmd, coord_x, coord_y, value));
    end
    pending <= pending_stencils.size();
  end

endmodule

// File: tb/periodic_grid_stencil_store_tb.sv
module periodic_grid_stencil_store_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pgss_pkg::*;

  // quiet cycles allowed before the run is declared hung; the limit lies far
  // above the time of a read and the longest gap that the sender inserts
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_QUOTA = 125;
  localparam int GRID_WORDS  = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  // command code the block must treat as a no-op with an all-zero result
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      start;
  logic [CMD_W-1:0]          cmd;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [DATA_W-1:0]  value;
  logic                      cfg_write;
  logic [CFG_IDX_W-1:0]      cfg_index;
  logic [CFG_W-1:0]          cfg_data;
  wire                       busy;
  wire                       done;
  wire signed [DATA_W-1:0]   up_left;
  wire signed [DATA_W-1:0]   up_mid;
  wire signed [DATA_W-1:0]   up_right;
  wire signed [DATA_W-1:0]   mid_left;
  wire signed [DATA_W-1:0]   center;
  wire signed [DATA_W-1:0]   mid_right;
  wire signed [DATA_W-1:0]   down_left;
  wire signed [DATA_W-1:0]   down_mid;
  wire signed [DATA_W-1:0]   down_right;
  wire                       saturated;
  int                        pending_results;
  int                        fails;

  // stimulus-side bookkeeping: which lattice words hold data, so that no
  // read or add ever touches a word that was never written
  bit written [GRID_WORDS];
  int width_code  = 64;
  int height_code = 64;
  int sent;
  int reads;
  int writes;
  int adds;
  int unused;
  int settings;
  int quiet_cycles;
  bit gaps_on = 1'b1;

  int phase_w [12] = '{3, 0, 1, 64, 127, 5, 65, 2, 8, 7, 1, 100};
  int phase_h [12] = '{2, 0, 64, 1, 127, 7, 3, 100, 8, 1, 1, 4};

  always #5 clk = ~clk;

  periodic_grid_stencil_store dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .value      (value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .up_left    (up_left),
    .up_mid     (up_mid),
    .up_right   (up_right),
    .mid_left   (mid_left),
    .center     (center),
    .mid_right  (mid_right),
    .down_left  (down_left),
    .down_mid   (down_mid),
    .down_right (down_right),
    .saturated  (saturated)
  );

  periodic_grid_stencil_store_checker stencil_chk (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .cmd        (cmd),
    .coord_x    (coord_x),
    .coord_y    (coord_y),
    .value      (value),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .done       (done),
    .up_left    (up_left),
    .up_mid     (up_mid),
    .up_right   (up_right),
    .mid_left   (mid_left),
    .center     (center),
    .mid_right  (mid_right),
    .down_left  (down_left),
    .down_mid   (down_mid),
    .down_right (down_right),
    .saturated  (saturated),
    .pending    (pending_results),
    .fails      (fails)
  );

  // effective lattice sizes as the block sees them
  function automatic int grid_w();
    if (width_code == 0) return 1;
    return (width_code > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : width_code;
  endfunction

  function automatic int grid_h();
    if (height_code == 0) return 1;
    return (height_code > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : height_code;
  endfunction

  function automatic int wrap_mod(int c, int n);
    int m;
    m = c % n;
    if (m < 0) m += n;
    return m;
  endfunction

  function automatic int cell_of(int x, int y);
    return wrap_mod(x, grid_w()) + wrap_mod(y, grid_h()) * grid_w();
  endfunction

  // coordinate mix: full range, multiples of the size (both signs) +-1,
  // the 16-bit extremes, and a small hot spot so large grids fill up
  function automatic int pick_coord(int span);
    int reach;
    int k;
    int c;
    reach = 32767 / span;
    case ($urandom_range(9))
      0, 1, 2: c = int'($urandom_range(65535)) - 32768;
      3, 4: begin
        k = int'($urandom_range(2 * reach)) - reach;
        c = k * span + int'($urandom_range(2)) - 1;
        if (c > 32767 || c < -32768) c = k * span;
      end
      5: c = $urandom_range(1) ? 32767 : -32768;
      6: c = -span;
      default: c = int'($urandom_range(5));
    endcase
    return c;
  endfunction

  // Q8.24 values: range ends, all ones, within +-1.0, and full random
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3, 4: return DATA_W'(int'($urandom_range(1 << 25)) - (1 << 24));
      default: return $urandom;
    endcase
  endfunction

  // Drive one request and hold it until the block takes it. start is left
  // high on return; the caller either sends the next request in the same
  // step or lowers it, so it never drops and rises within one step.
  task automatic send_request(logic [CMD_W-1:0] op, int x, int y, logic [DATA_W-1:0] v);
    if (gaps_on && $urandom_range(99) < 29) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
    start   <= 1'b1;
    cmd     <= op;
    coord_x <= x[COORD_W-1:0];
    coord_y <= y[COORD_W-1:0];
    value   <= v;
    do @(posedge clk); while (busy);
    sent++;
    case (op)
      CMD_READ:  reads++;
      CMD_WRITE: writes++;
      CMD_ADD:   adds++;
      default:   unused++;
    endcase
    if (op == CMD_WRITE || op == CMD_ADD) written[cell_of(x, y)] = 1'b1;
  endtask

  // neighborhood read, preceded by writes to any neighbor still empty
  task automatic read_around(int x, int y);
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        if (!written[cell_of(x + dx, y + dy)])
          send_request(CMD_WRITE, wrap_mod(x + dx, grid_w()), wrap_mod(y + dy, grid_h()),
                       pick_value());
      end
    end
    send_request(CMD_READ, x, y, pick_value());
  endtask

  // an add reads the word first, so make sure it holds data
  task automatic add_at(int x, int y, logic [DATA_W-1:0] v);
    if (!written[cell_of(x, y)]) send_request(CMD_WRITE, x, y, pick_value());
    send_request(CMD_ADD, x, y, v);
  endtask

  // drop start and wait until every result is back
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // both size registers, back to back; only called while idle
  task automatic program_grid(int w, int h);
    cfg_write <= 1'b1;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= w[CFG_W-1:0];
    @(posedge clk);
    cfg_index <= REG_GRID_HEIGHT;
    cfg_data  <= h[CFG_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    width_code  = w;
    height_code = h;
    settings++;
  endtask

  // hang detector: counts edges at which neither channel moves
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int w;
    int h;
    int pick;
    int x;
    int y;
    int phase_end;

    rst       <= 1'b1;
    start     <= 1'b0;
    cmd       <= CMD_READ;
    coord_x   <= '0;
    coord_y   <= '0;
    value     <= '0;
    cfg_write <= 1'b0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, at the reset size of 64 x 64
    send_request(CMD_WRITE, 0, 0, 32'h7fff_ffff);
    // negative multiple of the size lands on row zero; add clips high
    send_request(CMD_ADD, 64, -64, 32'h0000_0001);
    send_request(CMD_ADD, -32768, 0, 32'hffff_ffff);
    send_request(CMD_WRITE, 32767, 32767, 32'h8000_0000);
    // clips low, then a large positive add without clipping
    send_request(CMD_ADD, -1, -1, 32'h8000_0000);
    send_request(CMD_ADD, -1, -1, 32'h7fff_ffff);
    // unused command code: no state change, all-zero result
    send_request(CMD_UNUSED, 1, 1, 32'hdead_beef);
    // read at the coordinate extremes, wrapping on both axes
    read_around(-32768, 32767);

    // small grid: a 3 x 2 neighborhood wraps twice on the short axis
    settle();
    program_grid(3, 2);
    send_request(CMD_WRITE, -3, 2, 32'h0100_0000);
    read_around(-32768, 32767);

    // random phases; the fixed list covers zero, one, the bound and oversize codes
    for (int p = 0; p < 14; p++) begin
      settle();
      if (p < 12) begin
        w = phase_w[p];
        h = phase_h[p];
      end else begin
        w = $urandom_range(127);
        h = $urandom_range(127);
      end
      program_grid(w, h);
      phase_end = sent + PHASE_QUOTA;
      while (sent < phase_end) begin
        // one long stretch of back-to-back requests
        gaps_on = !(sent >= 700 && sent < 1000);
        pick = $urandom_range(99);
        x = pick_coord(grid_w());
        y = pick_coord(grid_h());
        if (pick < 40) read_around(x, y);
        else if (pick < 70) send_request(CMD_WRITE, x, y, pick_value());
        else if (pick < 95) add_at(x, y, pick_value());
        else send_request(CMD_UNUSED, x, y, pick_value());
      end
    end

    // drain, then let the back end run out
    settle();
    repeat (30) @(posedge clk);

    $display("tb: %0d requests: %0d reads, %0d writes, %0d adds, %0d unused codes",
             sent, reads, writes, adds, unused);
    $display("tb: %0d grid settings incl. zero, one, full and oversize size codes", settings);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
